// ===== design/sstu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sstu_pkg;

    localparam int LINE_DEPTH  = 32;
    localparam int DIGIT_COUNT = 3;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int SUM_W  = $clog2(LINE_DEPTH + DIGIT_COUNT + 1);
    localparam int DIG_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CHAR_W = 8;
    localparam int SEG_W  = 8;
    localparam int DEN_W  = 3;
    localparam int CFG_W  = 14;
    localparam int CIDX_W = 2;
    localparam int HOLD_W = 16;

    localparam logic [CHAR_W-1:0] LINE_END_CHAR = 8'h24;

    localparam logic [CFG_W-1:0] FIRST_HOLD_RST = 14'd2000;
    localparam logic [CFG_W-1:0] STEP_HOLD_RST  = 14'd500;
    localparam logic [CFG_W-1:0] LAST_EXTRA_RST = 14'd1500;

    localparam logic [CIDX_W-1:0] REG_FIRST_HOLD = 2'd0;
    localparam logic [CIDX_W-1:0] REG_STEP_HOLD  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LAST_EXTRA = 2'd2;

    localparam int FONT_N = 37;
    localparam logic [SEG_W-1:0] FONT [FONT_N] = '{
        8'h84,
        8'hD7, 8'h06, 8'hE3, 8'hA7, 8'h36, 8'hB5, 8'hF5, 8'h07, 8'hF7, 8'hB7,
        8'h77, 8'hF4, 8'hD1, 8'hE6, 8'hF1, 8'h71, 8'hD5, 8'h76, 8'h06, 8'hC6,
        8'hF2, 8'hD0, 8'h45, 8'h64, 8'hE4, 8'h73, 8'h37, 8'h60, 8'hB5, 8'hF0,
        8'hD6, 8'h52, 8'h92, 8'h56, 8'hB6, 8'hC3
    };

    // one write port and one read address per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        off = '0;
        if (c == 8'h2E) begin
            return FONT[0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            off = c - 8'h30;
            return FONT[6'(off) + 6'd1];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            off = c - 8'h41;
            return FONT[6'(off) + 6'd11];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            off = c - 8'h61;
            return FONT[6'(off) + 6'd11];
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

// ===== design/sstu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sstu_ram (
    input  wire logic                          i_clk,
    input  wire sstu_pkg::t_ram_req            i_req,
    output logic [sstu_pkg::CHAR_W-1:0]        o_rdata
);

    logic [sstu_pkg::CHAR_W-1:0] r_mem [sstu_pkg::LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

// ===== design/scrolling_seven_segment_text_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick: S_OUT follows S_IDLE if no line is shown, else S_RD1, S_RD2 and, on an
//   advance, S_RD3 (one display read per cycle); S_OUT waits for the output register.
// Byte: taken in S_IDLE; a line's first byte adds a receive store sweep (S_CLR),
//   a terminating byte a receive-to-display copy through one read port (S_COPY).
// Reset (synchronous, active low): control cleared, then an S_INIT pass zeroes
//   the receive store while no item is taken; configuration writes work throughout.

module scrolling_seven_segment_text_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_action,
    input  wire logic [sstu_pkg::CHAR_W-1:0]   i_rx_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [sstu_pkg::SEG_W-1:0]         o_segments,
    output logic [sstu_pkg::DEN_W-1:0]         o_digit_enable,
    output logic                               o_scrolling,
    input  wire logic                          i_cfg_we,
    input  wire logic [sstu_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [sstu_pkg::CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CLR   = 9'b000000100,
        S_COPY  = 9'b000001000,
        S_CEND  = 9'b000010000,
        S_RD1   = 9'b000100000,
        S_RD2   = 9'b001000000,
        S_RD3   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    localparam logic [sstu_pkg::ADDR_W-1:0] LAST_IDX =
        sstu_pkg::ADDR_W'(sstu_pkg::LINE_DEPTH - 1);
    localparam logic [sstu_pkg::DIG_W-1:0] LAST_DIG =
        sstu_pkg::DIG_W'(sstu_pkg::DIGIT_COUNT - 1);
    localparam logic [sstu_pkg::SUM_W-1:0] DEPTH_S =
        sstu_pkg::SUM_W'(sstu_pkg::LINE_DEPTH);

    t_state r_state, n_state;

    logic [sstu_pkg::CFG_W-1:0]  r_first, r_step, r_extra;

    logic [sstu_pkg::ADDR_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [sstu_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic [sstu_pkg::CHAR_W-1:0] r_byte, n_byte;
    logic                        r_cp_vld, n_cp_vld;
    logic [sstu_pkg::ADDR_W-1:0] r_cp_idx, n_cp_idx;

    logic                        r_active, n_active;
    logic [sstu_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic [sstu_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic [sstu_pkg::DIG_W-1:0]  r_digit, n_digit;
    logic                        r_oob, n_oob;

    // staged result of the tick in flight
    logic [sstu_pkg::SEG_W-1:0]  r_res_seg, n_res_seg;
    logic [sstu_pkg::DEN_W-1:0]  r_res_den, n_res_den;
    logic                        r_res_scr, n_res_scr;

    // output register
    logic                        r_o_valid, n_o_valid;
    logic [sstu_pkg::SEG_W-1:0]  r_o_seg, n_o_seg;
    logic [sstu_pkg::DEN_W-1:0]  r_o_den, n_o_den;
    logic                        r_o_scr, n_o_scr;

    sstu_pkg::t_ram_req          rx_req, disp_req;
    logic [sstu_pkg::CHAR_W-1:0] rx_rdata, disp_rdata;
    logic [sstu_pkg::CHAR_W-1:0] disp_ch;

    logic                        in_acc;
    logic [sstu_pkg::SUM_W-1:0]  sum_cur, sum_la, sum_la1;
    logic [7:0]                  den_full;

    sstu_ram u_rx_ram (
        .i_clk   (i_clk),
        .i_req   (rx_req),
        .o_rdata (rx_rdata)
    );

    sstu_ram u_disp_ram (
        .i_clk   (i_clk),
        .i_req   (disp_req),
        .o_rdata (disp_rdata)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign in_acc         = i_valid && o_ready;
    assign o_valid        = r_o_valid;
    assign o_segments     = r_o_seg;
    assign o_digit_enable = r_o_den;
    assign o_scrolling    = r_o_scr;

    // a store index at or past the end reads as zero
    assign disp_ch  = r_oob ? '0 : disp_rdata;
    assign sum_cur  = sstu_pkg::SUM_W'(r_pos) + sstu_pkg::SUM_W'(r_digit);
    assign sum_la   = sstu_pkg::SUM_W'(r_pos) + sstu_pkg::SUM_W'(sstu_pkg::DIGIT_COUNT);
    assign sum_la1  = sum_la + sstu_pkg::SUM_W'(1);
    // active-low select; digits past the third fall off the 3-bit field
    assign den_full = ~(8'd1 << r_digit);

    always_comb begin
        n_state   = r_state;
        n_rx_cnt  = r_rx_cnt;
        n_idx     = r_idx;
        n_byte    = r_byte;
        n_cp_vld  = 1'b0;
        n_cp_idx  = r_cp_idx;
        n_active  = r_active;
        n_pos     = r_pos;
        n_hold    = r_hold;
        n_digit   = r_digit;
        n_oob     = r_oob;
        n_res_seg = r_res_seg;
        n_res_den = r_res_den;
        n_res_scr = r_res_scr;
        n_o_valid = r_o_valid && !i_ready;
        n_o_seg   = r_o_seg;
        n_o_den   = r_o_den;
        n_o_scr   = r_o_scr;

        rx_req       = '0;
        disp_req     = '0;
        // copy pipeline: write the word read out of the receive store last cycle
        disp_req.we    = r_cp_vld;
        disp_req.waddr = r_cp_idx;
        disp_req.wdata = rx_rdata;

        unique case (r_state)
            S_INIT: begin
                rx_req.we    = 1'b1;
                rx_req.waddr = r_idx;
                rx_req.wdata = '0;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_action) begin
                        if (i_rx_byte == sstu_pkg::LINE_END_CHAR || r_rx_cnt == LAST_IDX) begin
                            // terminate the line, drop the byte, start the copy
                            rx_req.we    = 1'b1;
                            rx_req.waddr = r_rx_cnt;
                            rx_req.wdata = '0;
                            n_rx_cnt     = '0;
                            n_pos        = '0;
                            n_active     = 1'b1;
                            n_hold       = sstu_pkg::HOLD_W'(r_first);
                            n_idx        = '0;
                            n_state      = S_COPY;
                        end else if (r_rx_cnt == '0) begin
                            // line start: sweep the store, first entry gets the byte
                            n_byte  = i_rx_byte;
                            n_idx   = '0;
                            n_state = S_CLR;
                        end else begin
                            rx_req.we    = 1'b1;
                            rx_req.waddr = r_rx_cnt;
                            rx_req.wdata = i_rx_byte;
                            n_rx_cnt     = r_rx_cnt + 1'b1;
                        end
                    end else if (r_active) begin
                        disp_req.raddr = sum_cur[sstu_pkg::ADDR_W-1:0];
                        n_oob          = (sum_cur >= DEPTH_S);
                        n_state        = S_RD1;
                    end else begin
                        n_res_seg = '0;
                        n_res_den = '1;
                        n_res_scr = 1'b0;
                        n_state   = S_OUT;
                    end
                end
            end
            S_CLR: begin
                rx_req.we    = 1'b1;
                rx_req.waddr = r_idx;
                rx_req.wdata = (r_idx == '0) ? r_byte : '0;
                if (r_idx == LAST_IDX) begin
                    n_rx_cnt = sstu_pkg::ADDR_W'(1);
                    n_idx    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_COPY: begin
                rx_req.raddr = r_idx;
                n_cp_vld     = 1'b1;
                n_cp_idx     = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_CEND;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CEND: begin
                // last copy write drains here
                n_state = S_IDLE;
            end
            S_RD1: begin
                n_res_seg      = sstu_pkg::glyph(disp_ch);
                n_res_den      = den_full[sstu_pkg::DEN_W-1:0];
                n_res_scr      = 1'b1;
                disp_req.raddr = sum_la[sstu_pkg::ADDR_W-1:0];
                n_oob          = (sum_la >= DEPTH_S);
                n_state        = S_RD2;
            end
            S_RD2: begin
                if (r_hold != '0) begin
                    n_hold  = r_hold - 1'b1;
                    n_state = S_OUT;
                end else if (disp_ch != '0) begin
                    // advance and look one place further for the final view
                    n_hold         = sstu_pkg::HOLD_W'(r_step);
                    n_pos          = r_pos + 1'b1;
                    disp_req.raddr = sum_la1[sstu_pkg::ADDR_W-1:0];
                    n_oob          = (sum_la1 >= DEPTH_S);
                    n_state        = S_RD3;
                end else begin
                    n_active = 1'b0;
                    n_hold   = '0;
                    n_state  = S_OUT;
                end
            end
            S_RD3: begin
                if (disp_ch == '0) begin
                    n_hold = r_hold + sstu_pkg::HOLD_W'(r_extra);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_seg   = r_res_seg;
                    n_o_den   = r_res_den;
                    n_o_scr   = r_res_scr;
                    n_digit   = (r_digit == LAST_DIG) ? '0 : r_digit + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_rx_cnt  <= '0;
            r_idx     <= '0;
            r_cp_vld  <= 1'b0;
            r_active  <= 1'b0;
            r_pos     <= '0;
            r_hold    <= '0;
            r_digit   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_cnt  <= n_rx_cnt;
            r_idx     <= n_idx;
            r_cp_vld  <= n_cp_vld;
            r_active  <= n_active;
            r_pos     <= n_pos;
            r_hold    <= n_hold;
            r_digit   <= n_digit;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_cp_idx  <= n_cp_idx;
        r_oob     <= n_oob;
        r_res_seg <= n_res_seg;
        r_res_den <= n_res_den;
        r_res_scr <= n_res_scr;
        r_o_seg   <= n_o_seg;
        r_o_den   <= n_o_den;
        r_o_scr   <= n_o_scr;
    end

    // configuration registers; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= sstu_pkg::FIRST_HOLD_RST;
            r_step  <= sstu_pkg::STEP_HOLD_RST;
            r_extra <= sstu_pkg::LAST_EXTRA_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sstu_pkg::REG_FIRST_HOLD) begin
                r_first <= i_cfg_data;
            end
            if (i_cfg_index == sstu_pkg::REG_STEP_HOLD) begin
                r_step <= i_cfg_data;
            end
            if (i_cfg_index == sstu_pkg::REG_LAST_EXTRA) begin
                r_extra <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import sstu_pkg::*;

    // item kinds on the input channel
    localparam bit ACT_BYTE = 1'b0;
    localparam bit ACT_TICK = 1'b1;

    // index past the last register, must be ignored by the block
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [CFG_W-1:0] HOLD_MAX = 14'h3FFF;

    // cycles the block may still be busy after the last tick result
    // (terminating byte copy plus slack)
    localparam int SETTLE_CYCLES = 40;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 600;

    // character font, index 0 is the dot, then digits, then letters
    localparam logic [0:36][7:0] SEG_FONT = {
        8'h84,
        8'hD7, 8'h06, 8'hE3, 8'hA7, 8'h36, 8'hB5, 8'hF5, 8'h07, 8'hF7, 8'hB7,
        8'h77, 8'hF4, 8'hD1, 8'hE6, 8'hF1, 8'h71, 8'hD5, 8'h76, 8'h06, 8'hC6,
        8'hF2, 8'hD0, 8'h45, 8'h64, 8'hE4, 8'h73, 8'h37, 8'h60, 8'hB5, 8'hF0,
        8'hD6, 8'h52, 8'h92, 8'h56, 8'hB6, 8'hC3
    };

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [DEN_W-1:0] digit_enable;
        logic             scrolling;
    } tick_view_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_action    = 1'b0;
    logic [CHAR_W-1:0] i_rx_byte   = '0;
    logic              i_ready     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    logic              o_ready;
    logic              o_valid;
    logic [SEG_W-1:0]  o_segments;
    logic [DEN_W-1:0]  o_digit_enable;
    logic              o_scrolling;

    scrolling_seven_segment_text_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segments     (o_segments),
        .o_digit_enable (o_digit_enable),
        .o_scrolling    (o_scrolling),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Display predictor: own copy of the line stores, scroll state and
    // hold registers, advanced at each accepted transfer
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] rx_line    [LINE_DEPTH];
    logic [CHAR_W-1:0] shown_line [LINE_DEPTH];
    int unsigned       rx_count;
    bit                showing;
    int unsigned       view_pos;
    int unsigned       hold_left;
    int unsigned       digit_sel;
    int unsigned       first_hold = FIRST_HOLD_RST;
    int unsigned       step_hold  = STEP_HOLD_RST;
    int unsigned       last_extra = LAST_EXTRA_RST;

    tick_view_t        glyph_q [$];
    tick_view_t        want;
    int unsigned       mismatches;
    int unsigned       idle_count;
    int unsigned       random_sent;
    bit                no_idle;

    initial begin
        foreach (rx_line[i]) begin
            rx_line[i]    = '0;
            shown_line[i] = '0;
        end
    end

    // read past the end of the line returns the end mark
    function automatic logic [CHAR_W-1:0] shown_char(input int unsigned idx);
        if (idx >= LINE_DEPTH) return '0;
        return shown_line[idx];
    endfunction

    function automatic logic [SEG_W-1:0] char_segments(input logic [CHAR_W-1:0] ch);
        if (ch == ".") return SEG_FONT[0];
        if (ch >= "0" && ch <= "9") return SEG_FONT[1 + int'(ch - "0")];
        if (ch >= "A" && ch <= "Z") return SEG_FONT[11 + int'(ch - "A")];
        if (ch >= "a" && ch <= "z") return SEG_FONT[11 + int'(ch - "a")];
        return '0;
    endfunction

    function automatic void absorb_byte(input logic [CHAR_W-1:0] ch);
        if (rx_count >= LINE_DEPTH) rx_count = 0;
        if (ch == LINE_END_CHAR || rx_count == LINE_DEPTH - 1) begin
            // close the line and start showing it from the left
            rx_line[rx_count] = '0;
            view_pos  = 0;
            showing   = 1'b1;
            rx_count  = 0;
            hold_left = first_hold;
            shown_line = rx_line;
        end else begin
            if (rx_count == 0) begin
                foreach (rx_line[i]) rx_line[i] = '0;
            end
            rx_line[rx_count] = ch;
            rx_count++;
        end
    endfunction

    function automatic void advance_tick();
        tick_view_t v;
        if (showing) begin
            v.segments     = char_segments(shown_char(view_pos + digit_sel));
            v.digit_enable = ~(3'b001 << digit_sel);
            v.scrolling    = 1'b1;
            if (hold_left == 0) begin
                if (shown_char(view_pos + DIGIT_COUNT) != 0) begin
                    hold_left = step_hold;
                    view_pos++;
                    if (shown_char(view_pos + DIGIT_COUNT) == 0) hold_left += last_extra;
                end else begin
                    showing   = 1'b0;
                    hold_left = 0;
                end
            end else begin
                hold_left--;
            end
        end else begin
            v.segments     = '0;
            v.digit_enable = 3'b111;
            v.scrolling    = 1'b0;
        end
        glyph_q.push_back(v);
        digit_sel = (digit_sel + 1 >= DIGIT_COUNT) ? 0 : digit_sel + 1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare every output transfer with the oldest
    // predicted view
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (glyph_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: seg %h den %h scr %b",
                             $realtime, o_segments, o_digit_enable, o_scrolling);
            end else begin
                want = glyph_q.pop_front();
                if (o_segments !== want.segments || o_digit_enable !== want.digit_enable
                        || o_scrolling !== want.scrolling) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: seg exp %h got %h, den exp %h got %h, scr exp %b got %b",
                                 $realtime, want.segments, o_segments, want.digit_enable,
                                 o_digit_enable, want.scrolling, o_scrolling);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel makes a transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long; none while no_idle
    // ------------------------------------------------------------------
    function automatic int pick_pause();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver side: alternate ready runs with stalls
    initial begin
        int run_len;
        int stall;
        forever begin
            run_len = $urandom_range(1, 20);
            stall   = pick_pause();
            i_ready <= 1'b1;
            repeat (run_len) @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Present one item and hold it until the transfer, then predict.
    task automatic send_item(input bit act, input logic [CHAR_W-1:0] ch);
        int pause;
        pause = pick_pause();
        @(negedge i_clk);
        if (pause > 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_rx_byte <= ch;
        do @(posedge i_clk); while (!o_ready);
        if (act == ACT_TICK) advance_tick();
        else absorb_byte(ch);
        if (act == ACT_BYTE || act == ACT_TICK) random_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, '0);
    endtask

    // Drop valid, wait for every predicted view, then let the block finish
    // any line copy before touching the registers.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (glyph_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_FIRST_HOLD: first_hold = val;
            REG_STEP_HOLD:  step_hold  = val;
            REG_LAST_EXTRA: last_extra = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_holds(input logic [CFG_W-1:0] fh, input logic [CFG_W-1:0] sh,
                               input logic [CFG_W-1:0] le);
        settle();
        write_reg(REG_FIRST_HOLD, fh);
        write_reg(REG_STEP_HOLD, sh);
        write_reg(REG_LAST_EXTRA, le);
    endtask

    // Mostly printable font characters, some end marks and raw bytes.
    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return 8'("A" + $urandom_range(0, 25));
        if (r < 40) return 8'("a" + $urandom_range(0, 25));
        if (r < 65) return 8'("0" + $urandom_range(0, 9));
        if (r < 75) return ".";
        if (r < 82) return '0;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Ticks with nothing shown; digit index still advances. Poke the
    // unused register index too.
    task automatic test_idle_ticks();
        write_reg(REG_UNUSED, 14'($urandom_range(0, 16383)));
        send_ticks(4);
    endtask

    // Line shown under the reset hold values.
    task automatic test_reset_hold();
        send_text("8$");
        send_ticks(2);
    endtask

    // Both letter cases, digits and dot; short holds so the line scrolls
    // and then runs out.
    task automatic test_case_folding();
        write_holds(14'd1, 14'd0, 14'd2);
        send_text("aZ.09$");
        send_ticks(9);
    endtask

    // Terminator at count zero: only entry zero is cleared, the rest of
    // the old line is shown again.
    task automatic test_empty_line();
        send_text("$");
        send_ticks(2);
    endtask

    // A zero byte is stored and shows blank, but later characters still
    // keep the line scrolling.
    task automatic test_zero_byte();
        send_item(ACT_BYTE, '0);
        send_text("7K4$");
        send_ticks(4);
    endtask

    // ------------------------------------------------------------------
    // Random traffic in phases, each with its own hold settings
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int phase;
        int n_seq;
        int len;
        int full;
        int kind;
        logic [CFG_W-1:0] h [3];
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            // first two phases pin the extremes, later ones are mostly short
            foreach (h[i]) begin
                if (phase == 0) h[i] = HOLD_MAX;
                else if (phase == 1) h[i] = '0;
                else if ($urandom_range(0, 99) < 8) h[i] = HOLD_MAX;
                else h[i] = 14'($urandom_range(0, 3));
            end
            write_holds(h[0], h[1], h[2]);
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 14'($urandom()));
            no_idle = (phase % 4 == 2);

            n_seq = $urandom_range(1, 4);
            repeat (n_seq) begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    // well-formed line: text, terminator, ticks to watch it
                    kind = $urandom_range(0, 99);
                    if (kind < 70) len = $urandom_range(0, 8);
                    else if (kind < 90) len = $urandom_range(9, 30);
                    else len = $urandom_range(31, 34);
                    repeat (len) send_item(ACT_BYTE, pick_char());
                    send_item(ACT_BYTE, LINE_END_CHAR);
                    full = first_hold + (len + 2) * (step_hold + 1) + last_extra + 3;
                    if (full <= 150 && $urandom_range(0, 99) < 40) send_ticks(full);
                    else send_ticks($urandom_range(1, 24));
                end else if (kind < 90) begin
                    // broken line: text with no terminator, then ticks
                    repeat ($urandom_range(1, 10)) send_item(ACT_BYTE, pick_char());
                    send_ticks($urandom_range(1, 8));
                end else begin
                    // noise: any kind, any byte
                    repeat ($urandom_range(4, 12))
                        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, directed tests, random traffic, final drain
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_reset_hold();
        test_case_folding();
        test_empty_line();
        test_zero_byte();
        test_random_traffic();

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
